[rtl/core/overwriting_trace_ring_buffer_top_macros.svh]
// Assertion macros for the trace ring buffer.
// Used by the RTL modules that carry concurrent checks; needs nothing else.
`ifndef OVERWRITING_TRACE_RING_BUFFER_TOP_MACROS_SVH
`define OVERWRITING_TRACE_RING_BUFFER_TOP_MACROS_SVH

// Expression must hold at every edge outside reset
`define TRB_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("trace buffer check failed");

// Consequent must hold in the same cycle as the antecedent
`define TRB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trace buffer check failed");

// Consequent must hold in the cycle after the antecedent
`define TRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trace buffer check failed");

`endif

[rtl/core/trb_pkg.sv]
// Shared types and constants for the trace ring buffer.
// No dependencies.
`default_nettype none

package trb_pkg;

  // Operation codes carried by each input word
  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_INIT   = 2'd3
  } op_t;

  // Parameter A of the boot record
  localparam logic [31:0] BOOT_MARK = 32'h424F_4F54;

  // One stored trace entry
  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  code;
    logic [31:0] param_a;
    logic [31:0] param_b;
  } entry_t;

  // Read outcome handed from the controller to the result pipeline
  typedef struct packed {
    logic is_read;
    logic err;
  } rd_meta_t;

endpackage

`default_nettype wire

[rtl/core/overwriting_trace_ring_buffer_top.sv]
// Trace ring buffer top level: input decode, entry store and result register.
// Depends on trb_pkg, trb_ctrl and trb_mem.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation word: record,
//   read by index, clear or init. Each accepted word yields exactly one result
//   word on the output channel (out_valid / out_stall), in order.
//   The boot event code is to be written through cfg_we / cfg_data only while
//   idle; the block itself does not enforce this. A result passes through the
//   synchronous read of the entry store, then the result register.
//   Throughput: one word per cycle while in_stall is low; the store takes at
//   most one access per word and pointer and count update at the accept edge.
//   Stall: the result register holds while out_stall is high; a second word
//   waits in the read stage, and in_stall rises once both are occupied.
//   Reset: the buffer is disarmed and empty, the boot code is zero and both
//   pipeline stages are empty. Records made before the first init are
//   ignored. The entry store itself is not cleared.
`default_nettype none

module overwriting_trace_ring_buffer_top #(
  parameter int DEPTH = 64
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire  [7:0]                  cfg_data,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [1:0]                  opcode,
  input  wire  [7:0]                  event_code,
  input  wire  [31:0]                 param_a,
  input  wire  [31:0]                 param_b,
  input  wire  [31:0]                 time_stamp,
  input  wire  [$clog2(DEPTH+1)-1:0]  read_index,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        status,
  output logic [31:0]                 out_time_stamp,
  output logic [7:0]                  out_event,
  output logic [31:0]                 out_param_a,
  output logic [31:0]                 out_param_b,
  output logic [$clog2(DEPTH+1)-1:0]  entry_total
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic              accept, s1_adv;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  trb_pkg::entry_t   mem_wdata, mem_rdata;
  trb_pkg::rd_meta_t meta, s1_meta;
  logic [CW-1:0]     count_next, s1_count;
  logic              s1_valid;

  // Handshakes
  assign in_stall = s1_valid & out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign s1_adv   = s1_valid & (~out_valid | ~out_stall);

  trb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .op         (trb_pkg::op_t'(opcode)),
    .event_code (event_code),
    .param_a    (param_a),
    .param_b    (param_b),
    .time_stamp (time_stamp),
    .read_index (read_index),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .meta       (meta),
    .count_next (count_next)
  );

  trb_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Read stage: word in flight while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta  <= meta;
      s1_count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_adv | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status      <= s1_meta.err;
      entry_total <= s1_count;
      if (s1_meta.is_read && !s1_meta.err) begin
        out_time_stamp <= mem_rdata.stamp;
        out_event      <= mem_rdata.code;
        out_param_a    <= mem_rdata.param_a;
        out_param_b    <= mem_rdata.param_b;
      end else begin
        out_time_stamp <= '0;
        out_event      <= '0;
        out_param_a    <= '0;
        out_param_b    <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/trb_mem.sv]
// Entry store of the trace ring buffer: one write port, one registered read port.
// Depends on trb_pkg for the entry type.
`default_nettype none

module trb_mem #(
  parameter int DEPTH = 64
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [$clog2(DEPTH)-1:0]  waddr,
  input  trb_pkg::entry_t           wdata,
  input  wire                       re,
  input  wire  [$clog2(DEPTH)-1:0]  raddr,
  output trb_pkg::entry_t           rdata
);

  trb_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/trb_ctrl.sv]
// Pointer, count and arm state of the trace ring buffer, plus store addressing.
// Depends on trb_pkg and the assertion macro header.
`default_nettype none
`include "overwriting_trace_ring_buffer_top_macros.svh"

module trb_ctrl #(
  parameter int DEPTH = 64
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire  [7:0]                  cfg_data,
  input  wire                         accept,
  input  trb_pkg::op_t                op,
  input  wire  [7:0]                  event_code,
  input  wire  [31:0]                 param_a,
  input  wire  [31:0]                 param_b,
  input  wire  [31:0]                 time_stamp,
  input  wire  [$clog2(DEPTH+1)-1:0]  read_index,
  output logic                        mem_we,
  output logic [$clog2(DEPTH)-1:0]    mem_waddr,
  output trb_pkg::entry_t             mem_wdata,
  output logic                        mem_re,
  output logic [$clog2(DEPTH)-1:0]    mem_raddr,
  output trb_pkg::rd_meta_t           meta,
  output logic [$clog2(DEPTH+1)-1:0]  count_next
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [AW-1:0] wp, wp_next, wp_inc;
  logic [CW-1:0] count, count_inc;
  logic          armed, armed_next;
  logic [7:0]    boot_code;
  logic          read_ok;
  logic [AW:0]   rd_sum;

  // Boot event code register
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_code <= '0;
    end else if (cfg_we) begin
      boot_code <= cfg_data;
    end
  end

  // Wrapping and saturating steps
  assign wp_inc    = (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
  assign count_inc = (count == CW'(DEPTH)) ? count : count + 1'b1;

  // Read address: oldest entry sits at the write pointer once full
  assign read_ok = read_index < count;
  assign rd_sum  = {1'b0, wp} + {1'b0, read_index[AW-1:0]};
  always_comb begin
    if (count != CW'(DEPTH)) begin
      mem_raddr = read_index[AW-1:0];
    end else if (rd_sum >= (AW+1)'(DEPTH)) begin
      mem_raddr = AW'(rd_sum - (AW+1)'(DEPTH));
    end else begin
      mem_raddr = rd_sum[AW-1:0];
    end
  end

  // Per-operation decode
  always_comb begin
    wp_next      = wp;
    count_next   = count;
    armed_next   = armed;
    mem_we       = 1'b0;
    mem_waddr    = wp;
    mem_wdata    = '{stamp: time_stamp, code: event_code,
                     param_a: param_a, param_b: param_b};
    mem_re       = 1'b0;
    meta.is_read = 1'b0;
    meta.err     = 1'b0;
    unique case (op)
      trb_pkg::OP_RECORD: begin
        if (armed) begin
          mem_we     = 1'b1;
          wp_next    = wp_inc;
          count_next = count_inc;
        end
      end
      trb_pkg::OP_READ: begin
        meta.is_read = 1'b1;
        meta.err     = ~read_ok;
        mem_re       = read_ok;
      end
      trb_pkg::OP_CLEAR: begin
        wp_next    = '0;
        count_next = '0;
      end
      trb_pkg::OP_INIT: begin
        // Empty, arm and write the boot record in slot zero
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = '{stamp: time_stamp, code: boot_code,
                       param_a: trb_pkg::BOOT_MARK, param_b: 32'd0};
        wp_next    = AW'(1);
        count_next = CW'(1);
        armed_next = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    mem_we = mem_we & accept;
    mem_re = mem_re & accept;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      count <= '0;
      armed <= 1'b0;
    end else if (accept) begin
      wp    <= wp_next;
      count <= count_next;
      armed <= armed_next;
    end
  end

  `TRB_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `TRB_ASSERT_ALWAYS(a_wp_bound, clk, rst, wp <= AW'(DEPTH-1))
  `TRB_ASSERT_IMPLIES(a_wp_tracks_count, clk, rst, count != CW'(DEPTH), CW'(wp) == count)
  `TRB_ASSERT_IMPLIES(a_unarmed_empty, clk, rst, !armed, count == '0)
  `TRB_ASSERT_NEXT(a_clear_empties, clk, rst, accept && op == trb_pkg::OP_CLEAR, count == '0)

endmodule

`default_nettype wire
